### rtl/core/dsf_pkg.sv
// types, constants and helper functions shared by the dsf block deinterleaver
package dsf_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned BlockBytes  = 4096;
  localparam int unsigned StoreDepth  = MaxChannels * BlockBytes;
  localparam int unsigned StoreAw     = $clog2(StoreDepth);

  localparam int unsigned ChW     = 4;
  localparam int unsigned BsW     = 13;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ChIdxW  = 3;
  localparam int unsigned FillW   = StoreAw + 1;
  localparam int unsigned PosW    = FillW;
  localparam int unsigned AddrW   = StoreAw + 2;
  localparam int unsigned FrameW  = ChW + BsW;
  localparam int unsigned SpanW   = PosW + ChW + 1;
  localparam int unsigned CfgW    = BsW;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ChW-1:0] ChannelsRst  = 4'd2;
  localparam logic [BsW-1:0] BlockSizeRst = 13'd4096;
  localparam logic           LsbFirstRst  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHANNELS   = 2'd0,
    REG_BLOCK_SIZE = 2'd1,
    REG_LSB_FIRST  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [ByteW-1:0] data;
    logic             eod;
  } cmd_t;

  typedef struct packed {
    logic [ChW-1:0]    channels;
    logic [BsW-1:0]    block_size;
    logic              lsb_first;
    logic [FrameW-1:0] frame_bytes;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_START,
    ST_READ_DATA
  } back_state_e;

  function automatic logic [ChW-1:0] eff_channels(input logic [ChW-1:0] raw);
    logic [ChW-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = ChW'(1);
    end else if (raw > ChW'(MaxChannels)) begin
      res = ChW'(MaxChannels);
    end
    return res;
  endfunction

  function automatic logic [BsW-1:0] eff_block_size(input logic [BsW-1:0] raw);
    logic [BsW-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = BsW'(1);
    end else if (raw > BsW'(BlockBytes)) begin
      res = BsW'(BlockBytes);
    end
    return res;
  endfunction

  function automatic logic [ByteW-1:0] reverse_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] res;
    for (int k = 0; k < ByteW; k++) begin
      res[ByteW-1-k] = b[k];
    end
    return res;
  endfunction

endpackage

### rtl/core/dsf_front.sv
// front end: takes input words, turns them into load or read commands, two-entry queue
module dsf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           mode_i,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_data_i,
  output logic           cmd_valid_o,
  output dsf_pkg::cmd_t  cmd_o,
  input  logic           cmd_pop_i
);
  import dsf_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_in.kind = mode_i ? CMD_READ : CMD_LOAD;
    // data and end marker only mean something for a load
    cmd_in.data = mode_i ? '0 : data_byte_i;
    cmd_in.eod  = mode_i ? 1'b0 : end_of_data_i;
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/core/dsf_back.sv
// back end: block store, load bookkeeping, frame read-out sequencer and output register
module dsf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dsf_pkg::cfg_t  cfg_i,
  input  logic           cmd_valid_i,
  input  dsf_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     sample_byte_o,
  output logic [2:0]     channel_index_o,
  output logic           last_o,
  output logic           empty_res_o
);
  import dsf_pkg::*;

  logic [ByteW-1:0] store_q [StoreDepth];
  logic [ByteW-1:0] rd_data_q;
  logic             oob_q;

  back_state_e       state_q, state_d;
  logic              ready_q, ready_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [FillW-1:0]  valid_q, valid_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [ChIdxW-1:0] chan_q, chan_d;

  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q, out_byte_d;
  logic [ChIdxW-1:0] out_chan_q, out_chan_d;
  logic              out_last_q, out_last_d;
  logic              out_empty_q, out_empty_d;

  logic              out_free;
  logic              is_last;
  logic [PosW-1:0]   pos_op;
  logic [SpanW-1:0]  span;
  logic              run_out;
  logic [FillW-1:0]  fill_inc;
  logic              block_full;
  logic              wr_en;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic [ByteW-1:0]  rd_byte;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_last  = ({1'b0, chan_q} == (cfg_i.channels - ChW'(1)));
  // check the sample position against valid_bytes / channels without a divider:
  // pos >= floor(v / ch) exactly when pos * ch + ch > v
  assign pos_op   = (state_q == ST_READ_DATA) ? pos_q + PosW'(1) : pos_q;
  assign span     = SpanW'(pos_op) * SpanW'(cfg_i.channels) + SpanW'(cfg_i.channels);
  assign run_out  = (span > SpanW'(valid_q));
  assign fill_inc = fill_q + FillW'(1);
  assign block_full = (FrameW'(fill_inc) >= cfg_i.frame_bytes);
  assign rd_byte  = oob_q ? '0 : rd_data_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind == CMD_READ)) begin
          state_d = ST_READ_START;
        end
      end
      ST_READ_START: begin
        if (out_free) begin
          state_d = (!ready_q || run_out) ? ST_IDLE : ST_READ_DATA;
        end
      end
      ST_READ_DATA: begin
        if (out_free && is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cmd_pop_o   = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = addr_q;
    ready_d     = ready_q;
    fill_d      = fill_q;
    valid_d     = valid_q;
    pos_d       = pos_q;
    addr_d      = addr_q;
    chan_d      = chan_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_chan_d  = out_chan_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          // loads are dropped while a block is being drained
          if ((cmd_i.kind == CMD_LOAD) && !ready_q) begin
            wr_en  = !fill_q[StoreAw];
            fill_d = fill_inc;
            if (block_full || cmd_i.eod) begin
              ready_d = 1'b1;
              valid_d = fill_inc;
              pos_d   = '0;
              fill_d  = '0;
            end
          end
        end
      end
      ST_READ_START: begin
        if (out_free) begin
          if (!ready_q || run_out) begin
            ready_d     = 1'b0;
            valid_d     = '0;
            pos_d       = '0;
            out_valid_d = 1'b1;
            out_byte_d  = '0;
            out_chan_d  = '0;
            out_last_d  = 1'b0;
            out_empty_d = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(pos_q);
            addr_d  = AddrW'(pos_q) + AddrW'(cfg_i.block_size);
            chan_d  = '0;
          end
        end
      end
      ST_READ_DATA: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = cfg_i.lsb_first ? reverse_byte(rd_byte) : rd_byte;
          out_chan_d  = chan_q;
          out_last_d  = is_last;
          out_empty_d = 1'b0;
          if (is_last) begin
            pos_d = pos_op;
            if (run_out) begin
              ready_d = 1'b0;
              valid_d = '0;
              pos_d   = '0;
            end
          end else begin
            // fetch the next channel while this word goes out
            chan_d = chan_q + ChIdxW'(1);
            rd_en  = 1'b1;
            addr_d = addr_q + AddrW'(cfg_i.block_size);
          end
        end
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  // block store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[fill_q[StoreAw-1:0]] <= cmd_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= store_q[rd_addr[StoreAw-1:0]];
      // index past the store reads as zero
      oob_q     <= |rd_addr[AddrW-1:StoreAw];
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_chan_q  <= out_chan_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    addr_q      <= addr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ready_q     <= 1'b0;
      fill_q      <= '0;
      valid_q     <= '0;
      pos_q       <= '0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      fill_q      <= fill_d;
      valid_q     <= valid_d;
      pos_q       <= pos_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_byte_o   = out_byte_q;
  assign channel_index_o = out_chan_q;
  assign last_o          = out_last_q;
  assign empty_res_o     = out_empty_q;

endmodule

### rtl/core/dsf_block_deinterleaver.sv
// top level: configuration registers, front end command queue and back end
// Loads planar dsf blocks (channels x block_size bytes, or fewer when end_of_data
// closes the block) into a 32768-byte store and reads them out channel-interleaved.
// Loads stream at one word per clock while no read is in progress in the back end.
// A read first checks the block and starts the first store read, then gives one
// output word per channel, paced by the single store read port; a read that finds
// no sample returns one empty word. A two-entry command queue sits in front, and
// an output register lets the next command be taken while a word waits. Write
// configuration only while idle.
module dsf_block_deinterleaver (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dsf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dsf_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       end_of_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 sample_byte_o,
  output logic [2:0]                 channel_index_o,
  output logic                       last_o,
  output logic                       empty_res_o
);
  import dsf_pkg::*;

  logic [ChW-1:0]    channels_q;
  logic [BsW-1:0]    block_size_q;
  logic              lsb_first_q;
  logic [FrameW-1:0] frame_q, frame_d;
  logic [ChW-1:0]    eff_ch;
  logic [BsW-1:0]    eff_bs;
  cfg_t              cfg;
  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_pop;

  assign eff_ch  = eff_channels(channels_q);
  assign eff_bs  = eff_block_size(block_size_q);
  // block length is registered, config is quiet long before an item reaches the back end
  assign frame_d = FrameW'(eff_ch) * FrameW'(eff_bs);

  always_comb begin
    cfg.channels    = eff_ch;
    cfg.block_size  = eff_bs;
    cfg.lsb_first   = lsb_first_q;
    cfg.frame_bytes = frame_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q   <= ChannelsRst;
      block_size_q <= BlockSizeRst;
      lsb_first_q  <= LsbFirstRst;
      frame_q      <= FrameW'(ChannelsRst) * FrameW'(BlockSizeRst);
    end else begin
      frame_q <= frame_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_CHANNELS:   channels_q   <= cfg_wdata_i[ChW-1:0];
          REG_BLOCK_SIZE: block_size_q <= cfg_wdata_i[BsW-1:0];
          REG_LSB_FIRST:  lsb_first_q  <= cfg_wdata_i[0];
          default:        lsb_first_q  <= lsb_first_q;
        endcase
      end
    end
  end

  dsf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .data_byte_i   (data_byte_i),
    .end_of_data_i (end_of_data_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  dsf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_byte_o   (sample_byte_o),
    .channel_index_o (channel_index_o),
    .last_o          (last_o),
    .empty_res_o     (empty_res_o)
  );

endmodule

### test/dsf_frame_checker.sv
// checker for the dsf block deinterleaver: predicts every result word and compares it
module dsf_frame_checker
  import dsf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               mode_i,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               end_of_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [ByteW-1:0]   sample_byte_i,
  input  logic [ChIdxW-1:0]  channel_index_i,
  input  logic               last_i,
  input  logic               empty_res_i,
  output int                 pending_o,
  output int                 fail_count_o,
  output int                 words_checked_o
);

  typedef struct packed {
    logic [ByteW-1:0]  smp;
    logic [ChIdxW-1:0] chan;
    logic              lst;
    logic              emp;
  } frame_word_t;

  logic [ByteW-1:0] sample_mem [StoreDepth];
  frame_word_t      frame_q [$];

  logic [ChW-1:0] ch_reg;
  logic [BsW-1:0] bs_reg;
  logic           lsb_reg;
  int unsigned    fill_cnt;
  int unsigned    valid_cnt;
  int unsigned    read_pos;
  logic           blk_ready;
  int             mismatches;
  int             checked;

  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned nch;
    int unsigned nbs;
    int unsigned idx;
    int unsigned frames;
    logic [ByteW-1:0] raw;
    frame_word_t w;
    if (!rst_ni) begin
      ch_reg     = ChannelsRst;
      bs_reg     = BlockSizeRst;
      lsb_reg    = LsbFirstRst;
      fill_cnt   = 0;
      valid_cnt  = 0;
      read_pos   = 0;
      blk_ready  = 1'b0;
      mismatches = 0;
      checked    = 0;
      frame_q.delete();
      pending_o       <= 0;
      fail_count_o    <= 0;
      words_checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_CHANNELS:   ch_reg = cfg_wdata_i[ChW-1:0];
          REG_BLOCK_SIZE: bs_reg = cfg_wdata_i[BsW-1:0];
          REG_LSB_FIRST:  lsb_reg = cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (frame_q.size() == 0) begin
          $error("unexpected result word: sample_byte %02h channel_index %0d last %0b empty_res %0b",
                 sample_byte_i, channel_index_i, last_i, empty_res_i);
          mismatches++;
        end else begin
          w = frame_q.pop_front();
          if (sample_byte_i !== w.smp) begin
            $error("sample_byte: expected %02h, got %02h", w.smp, sample_byte_i);
            mismatches++;
          end
          if (channel_index_i !== w.chan) begin
            $error("channel_index: expected %0d, got %0d", w.chan, channel_index_i);
            mismatches++;
          end
          if (last_i !== w.lst) begin
            $error("last: expected %0b, got %0b", w.lst, last_i);
            mismatches++;
          end
          if (empty_res_i !== w.emp) begin
            $error("empty_res: expected %0b, got %0b", w.emp, empty_res_i);
            mismatches++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        // out of range settings clamp to the nearest legal value
        nch = (ch_reg == '0) ? 1 : ((ch_reg > MaxChannels) ? MaxChannels : ch_reg);
        nbs = (bs_reg == '0) ? 1 : ((bs_reg > BlockBytes) ? BlockBytes : bs_reg);
        if (cmd_kind_e'(mode_i) == CMD_LOAD) begin
          // loads are dropped while a block is still being read out
          if (!blk_ready) begin
            if (fill_cnt < StoreDepth) sample_mem[fill_cnt] = data_byte_i;
            fill_cnt++;
            if (fill_cnt >= nch * nbs || end_of_data_i) begin
              blk_ready = 1'b1;
              valid_cnt = fill_cnt;
              read_pos  = 0;
              fill_cnt  = 0;
            end
          end
        end else begin
          frames = valid_cnt / nch;
          if (blk_ready && read_pos >= frames) begin
            blk_ready = 1'b0;
            valid_cnt = 0;
            read_pos  = 0;
          end
          if (!blk_ready) begin
            w = '{smp: '0, chan: '0, lst: 1'b0, emp: 1'b1};
            frame_q.push_back(w);
          end else begin
            for (int c = 0; c < nch; c++) begin
              idx = c * nbs + read_pos;
              raw = (idx < StoreDepth) ? sample_mem[idx] : '0;
              if (lsb_reg) raw = {<<{raw}};
              w = '{smp: raw, chan: ChIdxW'(c), lst: (c == nch - 1), emp: 1'b0};
              frame_q.push_back(w);
            end
            read_pos++;
            if (read_pos >= frames) begin
              blk_ready = 1'b0;
              valid_cnt = 0;
              read_pos  = 0;
            end
          end
        end
      end

      pending_o       <= frame_q.size();
      fail_count_o    <= mismatches;
      words_checked_o <= checked;
    end
  end

endmodule

### test/tb_top.sv
// testbench top: stimulus, idling and verdict for the dsf block deinterleaver
module tb_top;
  import dsf_pkg::*;

  localparam int QuietLimit   = 2000;
  localparam int SettleCycles = 24;
  localparam int PhaseItems   = 72;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = 1'b0;
  logic [7:0]         data_byte = '0;
  logic               end_of_data = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         sample_byte;
  logic [2:0]         channel_index;
  logic               last;
  logic               empty_res;

  int pending;
  int fail_count;
  int words_checked;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int words_sent = 0;
  int settings_used = 0;

  // rough picture of the block's fill state, used only to shape the stimulus
  int unsigned plan_fill = 0;
  int unsigned plan_valid = 0;
  int unsigned plan_pos = 0;
  int unsigned ch_eff = 2;
  int unsigned bs_eff = 4096;
  bit          plan_ready = 1'b0;
  int unsigned blk_target = 1;

  dsf_block_deinterleaver DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .data_byte_i     (data_byte),
    .end_of_data_i   (end_of_data),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .sample_byte_o   (sample_byte),
    .channel_index_o (channel_index),
    .last_o          (last),
    .empty_res_o     (empty_res)
  );

  dsf_frame_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .mode_i          (mode),
    .data_byte_i     (data_byte),
    .end_of_data_i   (end_of_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .sample_byte_i   (sample_byte),
    .channel_index_i (channel_index),
    .last_i          (last),
    .empty_res_i     (empty_res),
    .pending_o       (pending),
    .fail_count_o    (fail_count),
    .words_checked_o (words_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stalls in bursts, each started at random with a chance of rx_idle_pct percent
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!out_stall && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      stall_left <= $urandom_range(0, 7);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned pick_block_len();
    int unsigned cap;
    cap = ch_eff * bs_eff;
    // full blocks close by themselves, the rest are cut short by end_of_data
    if (cap <= 48 && $urandom_range(0, 1) == 1) return cap + 1;
    return $urandom_range(1, (cap < 48) ? cap : 48);
  endfunction

  task automatic drive_word(input cmd_kind_e kind, input logic [7:0] data, input logic eod);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= kind;
    data_byte   <= data;
    end_of_data <= eod;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (kind == CMD_LOAD) begin
      if (!plan_ready) begin
        plan_fill++;
        if (plan_fill >= ch_eff * bs_eff || eod) begin
          plan_ready = 1'b1;
          plan_valid = plan_fill;
          plan_pos   = 0;
          plan_fill  = 0;
        end
      end
    end else begin
      if (plan_ready && plan_pos >= plan_valid / ch_eff) plan_ready = 1'b0;
      if (plan_ready) begin
        plan_pos++;
        if (plan_pos >= plan_valid / ch_eff) plan_ready = 1'b0;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // loads give no result, so let the command queue run dry as well
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic program_cfg(input logic [3:0] ch, input logic [12:0] bs, input logic lsb);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_CHANNELS;
    cfg_wdata <= CfgW'(ch);
    @(posedge clk);
    cfg_idx   <= REG_BLOCK_SIZE;
    cfg_wdata <= bs;
    @(posedge clk);
    cfg_idx   <= REG_LSB_FIRST;
    cfg_wdata <= CfgW'(lsb);
    @(posedge clk);
    cfg_we    <= 1'b0;
    ch_eff = (ch == 0) ? 1 : ((ch > MaxChannels) ? MaxChannels : ch);
    bs_eff = (bs == 0) ? 1 : ((bs > BlockBytes) ? BlockBytes : bs);
    settings_used++;
  endtask

  initial begin : stimulus
    int k;
    int n;
    logic [7:0] d;
    cmd_kind_e kind;
    logic eod;
    bit was_ready;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing loaded yet
    drive_word(CMD_READ, 8'h5a, 1'b1);

    // fill the whole store once with eight channels of 4096 bytes
    wait_drained();
    program_cfg(4'd8, 13'd4096, 1'b1);
    tx_idle_pct = 10;
    rx_idle_pct = 20;
    for (k = 0; k < StoreDepth; k++) begin
      if (k == 100) drive_word(CMD_READ, 8'ha5, 1'b0);
      case (k)
        0: d = 8'h00;
        1: d = 8'hff;
        2: d = 8'h01;
        3: d = 8'h80;
        default: d = 8'($urandom_range(0, 255));
      endcase
      drive_word(CMD_LOAD, d, 1'b0);
    end
    drive_word(CMD_LOAD, 8'hc3, 1'b1);
    for (k = 0; k < BlockBytes; k++) begin
      // sender holds off until every word of the first half is out
      if (k == BlockBytes / 2) wait_drained();
      drive_word(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    drive_word(CMD_READ, 8'h00, 1'b0);

    wait_drained();
    program_cfg(4'd1, 13'd1, 1'b0);
    drive_word(CMD_LOAD, 8'h00, 1'b0);
    drive_word(CMD_READ, 8'hff, 1'b1);
    drive_word(CMD_READ, 8'h00, 1'b0);
    drive_word(CMD_LOAD, 8'hff, 1'b1);
    drive_word(CMD_READ, 8'h00, 1'b0);

    // a block shorter than one frame reads back empty
    wait_drained();
    program_cfg(4'd3, 13'd2, 1'b1);
    drive_word(CMD_LOAD, 8'h96, 1'b1);
    drive_word(CMD_READ, 8'h00, 1'b0);
    for (k = 0; k < 5; k++) drive_word(CMD_LOAD, 8'($urandom_range(0, 255)), k == 4);
    drive_word(CMD_READ, 8'h00, 1'b0);
    drive_word(CMD_READ, 8'h00, 1'b0);

    wait_drained();
    program_cfg(4'd0, 13'd0, 1'b1);
    drive_word(CMD_LOAD, 8'h3c, 1'b0);
    drive_word(CMD_READ, 8'h00, 1'b0);

    wait_drained();
    program_cfg(4'd15, 13'd8191, 1'b0);
    for (k = 0; k < 8; k++) drive_word(CMD_LOAD, 8'($urandom_range(0, 255)), k == 7);
    drive_word(CMD_READ, 8'h00, 1'b0);
    drive_word(CMD_READ, 8'h00, 1'b0);

    for (int p = 0; p < 7; p++) begin
      wait_drained();
      case (p)
        0: begin program_cfg(4'd2, 13'd4, 1'b1); tx_idle_pct = 25; rx_idle_pct = 25; end
        1: begin program_cfg(4'd8, 13'd3, 1'b0); tx_idle_pct = 0;  rx_idle_pct = 0;  end
        2: begin
          program_cfg(4'($urandom_range(0, 15)), 13'($urandom_range(1, 12)),
                      1'($urandom_range(0, 1)));
          tx_idle_pct = 30;
          rx_idle_pct = 30;
        end
        3: begin program_cfg(4'd5, 13'd4096, 1'b1); tx_idle_pct = 15; rx_idle_pct = 15; end
        4: begin program_cfg(4'd1, 13'd7, 1'b0); tx_idle_pct = 0; rx_idle_pct = 40; end
        5: begin
          program_cfg(4'($urandom_range(0, 15)), 13'($urandom_range(0, 8191)),
                      1'($urandom_range(0, 1)));
          tx_idle_pct = 20;
          rx_idle_pct = 10;
        end
        default: begin program_cfg(4'd4, 13'd2, 1'b1); tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      blk_target = pick_block_len();
      n = 0;
      while (n < PhaseItems) begin
        // mostly whole blocks loaded then read out, with stray words mixed in
        if (plan_ready) kind = ($urandom_range(0, 9) == 0) ? CMD_LOAD : CMD_READ;
        else kind = ($urandom_range(0, 6) == 0) ? CMD_READ : CMD_LOAD;
        if (kind == CMD_LOAD)
          eod = (!plan_ready && plan_fill + 1 >= blk_target) || $urandom_range(0, 40) == 0;
        else
          eod = 1'($urandom_range(0, 1));
        was_ready = plan_ready;
        drive_word(kind, 8'($urandom_range(0, 255)), eod);
        if (!(kind == CMD_LOAD && was_ready)) n++;
        if (kind == CMD_LOAD && !was_ready && plan_ready) blk_target = pick_block_len();
        if (kind == CMD_READ && was_ready && !plan_ready && $urandom_range(0, 5) == 0)
          wait_drained();
      end
    end

    wait_drained();
    $display("sent %0d input words under %0d register settings, incl. a full store fill;",
             words_sent, settings_used);
    $display("checked %0d result words with both sides idling at random", words_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/dsf_pkg.sv
rtl/core/dsf_front.sv
rtl/core/dsf_back.sv
rtl/core/dsf_block_deinterleaver.sv
test/dsf_frame_checker.sv
test/tb_top.sv
